[rtl/core/bfa_pkg.sv]
`timescale 1ns / 1ps

package bfa_pkg;

   localparam int MODE_W    = 3;
   localparam int ADDR_IN_W = 52;
   localparam int QFRAME_W  = 24;
   localparam int ALLOC_W   = 27;
   localparam int COUNT_W   = 16;
   localparam int WORD_W    = 64;
   localparam int BIT_W     = 6;

   typedef enum logic [MODE_W-1:0] {
      MODE_RESET   = 3'd0,
      MODE_RELEASE = 3'd1,
      MODE_ALLOC   = 3'd2,
      MODE_FREE    = 3'd3,
      MODE_QUERY   = 3'd4
   } mode_type;

   typedef struct packed {
      logic capture;
      logic fill_start;
      logic fill_write;
      logic rel_prep_a;
      logic rel_prep_b;
      logic rel_setup;
      logic rel_eval;
      logic alloc_setup;
      logic alloc_eval;
      logic alloc_commit;
      logic tgt_setup;
      logic tgt_eval;
      logic rd_en;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic last_word;
      logic rel_last;
      logic rel_go;
      logic count_zero;
      logic hit;
      logic tgt_ok;
   } status_type;

endpackage

[rtl/core/bitmap_frame_allocator_top.sv]
// Physical frame allocator over a used/free bitmap kept in a 64-bit wide RAM.
// Requests arrive on the req_ channel and each one produces exactly one
// response on the rsp_ channel, carrying the allocated address, the query
// result and the free frame count after the request.
// The block works on one request at a time, and req_ready returns in the cycle
// after the response is loaded. A query or free reads the target bitmap word,
// but skips the read when the address or frame is out of range.
// An allocation scans bitmap words starting at the next-fit pointer, and
// skips the scan when no frame is free.
// A region release reads and rewrites each bitmap word covered, and skips
// this when the region is not usable or holds no whole frame in range.
// A reset request rewrites every bitmap word, one per cycle, before answering.
// After reset the bitmap RAM is swept to all used, one word per cycle, over
// (MAX_FRAMES + 63) / 64 words; req_ready stays low during the sweep.
// The response sits in an output register, so a new request is accepted while
// an earlier response still waits. If the receiver stalls, the next request
// holds in its final state until the output register is free.
`timescale 1ns / 1ps

module bitmap_frame_allocator_top
   import bfa_pkg::*;
#(
   parameter int MAX_FRAMES  = 32768,
   parameter int FRAME_BYTES = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [ADDR_IN_W-1:0] req_region_base,
   input  logic [ADDR_IN_W-1:0] req_region_length,
   input  logic                 req_region_usable,
   input  logic [ADDR_IN_W-1:0] req_free_address,
   input  logic [QFRAME_W-1:0]  req_query_frame,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ALLOC_W-1:0]   rsp_alloc_address,
   output logic                 rsp_frame_in_use,
   output logic [COUNT_W-1:0]   rsp_free_frames
);

   cmd_type    cmd;
   status_type status;

   bfa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode (req_mode),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .status   (status)
   );

   bfa_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .FRAME_BYTES(FRAME_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_region_base  (req_region_base),
      .req_region_length(req_region_length),
      .req_region_usable(req_region_usable),
      .req_free_address (req_free_address),
      .req_query_frame  (req_query_frame),
      .rsp_alloc_address(rsp_alloc_address),
      .rsp_frame_in_use (rsp_frame_in_use),
      .rsp_free_frames  (rsp_free_frames)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in progress");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("response register overwritten before it was taken");

   a_search_needs_free: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_setup |-> !status.count_zero)
      else $error("bitmap search started with no free frame");

   a_addr_excludes_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_alloc_address != '0)) |-> !rsp_frame_in_use)
      else $error("allocation response also reports a used frame");

endmodule

[rtl/core/bfa_ram.sv]
`timescale 1ns / 1ps

module bfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bfa_ctrl.sv]
`timescale 1ns / 1ps

module bfa_ctrl
   import bfa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [MODE_W-1:0] req_mode,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cmd_type           cmd,
   input  status_type        status
);

   typedef enum logic [3:0] {
      ST_FILL,
      ST_IDLE,
      ST_REL_A,
      ST_REL_B,
      ST_REL_C,
      ST_REL_RD,
      ST_REL_EV,
      ST_REL_TAIL,
      ST_ALLOC,
      ST_ALLOC_RD,
      ST_ALLOC_EV,
      ST_ALLOC_END,
      ST_CHK,
      ST_TGT_RD,
      ST_TGT_EV,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      resp_pend_ff, resp_pend_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      resp_pend_in = resp_pend_ff;
      cmd          = '0;
      case (state_ff)
         ST_FILL: begin
            cmd.fill_write = 1'b1;
            if (status.last_word) begin
               state_in     = resp_pend_ff ? ST_DONE : ST_IDLE;
               resp_pend_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_mode)
                  MODE_RESET: begin
                     cmd.fill_start = 1'b1;
                     resp_pend_in   = 1'b1;
                     state_in       = ST_FILL;
                  end
                  MODE_RELEASE: state_in = ST_REL_A;
                  MODE_ALLOC:   state_in = ST_ALLOC;
                  MODE_FREE:    state_in = ST_CHK;
                  MODE_QUERY:   state_in = ST_CHK;
                  default:      state_in = ST_DONE;
               endcase
            end
         end
         ST_REL_A: begin
            cmd.rel_prep_a = 1'b1;
            state_in       = ST_REL_B;
         end
         ST_REL_B: begin
            cmd.rel_prep_b = 1'b1;
            state_in       = ST_REL_C;
         end
         ST_REL_C: begin
            cmd.rel_setup = 1'b1;
            state_in      = status.rel_go ? ST_REL_RD : ST_DONE;
         end
         ST_REL_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_REL_EV;
         end
         ST_REL_EV: begin
            cmd.rel_eval = 1'b1;
            state_in     = status.rel_last ? ST_REL_TAIL : ST_REL_RD;
         end
         ST_REL_TAIL: begin
            state_in = ST_DONE;
         end
         ST_ALLOC: begin
            if (status.count_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.alloc_setup = 1'b1;
               state_in        = ST_ALLOC_RD;
            end
         end
         ST_ALLOC_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_ALLOC_EV;
         end
         ST_ALLOC_EV: begin
            cmd.alloc_eval = 1'b1;
            state_in       = status.hit ? ST_ALLOC_END : ST_ALLOC_RD;
         end
         ST_ALLOC_END: begin
            cmd.alloc_commit = 1'b1;
            state_in         = ST_DONE;
         end
         ST_CHK: begin
            cmd.tgt_setup = 1'b1;
            state_in      = status.tgt_ok ? ST_TGT_RD : ST_DONE;
         end
         ST_TGT_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_TGT_EV;
         end
         ST_TGT_EV: begin
            cmd.tgt_eval = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         rsp_valid_ff <= 1'b0;
         resp_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         resp_pend_ff <= resp_pend_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/bfa_datapath.sv]
`timescale 1ns / 1ps

module bfa_datapath
   import bfa_pkg::*;
#(
   parameter int MAX_FRAMES  = 32768,
   parameter int FRAME_BYTES = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [ADDR_IN_W-1:0] req_region_base,
   input  logic [ADDR_IN_W-1:0] req_region_length,
   input  logic                 req_region_usable,
   input  logic [ADDR_IN_W-1:0] req_free_address,
   input  logic [QFRAME_W-1:0]  req_query_frame,
   output logic [ALLOC_W-1:0]   rsp_alloc_address,
   output logic                 rsp_frame_in_use,
   output logic [COUNT_W-1:0]   rsp_free_frames
);

   localparam int FBL       = $clog2(FRAME_BYTES);
   localparam int FW        = $clog2(MAX_FRAMES);
   localparam int FW1       = $clog2(MAX_FRAMES + 1);
   localparam int CW        = FW1;
   localparam int MAP_WORDS = (MAX_FRAMES + WORD_W - 1) / WORD_W;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int EXT_W     = ADDR_IN_W + 1;
   localparam int POP_W     = BIT_W + 1;

   localparam logic [AW-1:0]     LAST_WORD = AW'(MAP_WORDS - 1);
   localparam logic [EXT_W-1:0]  SPAN      = EXT_W'(MAX_FRAMES) * EXT_W'(FRAME_BYTES);
   localparam logic [EXT_W-1:0]  FB_M1     = EXT_W'(FRAME_BYTES - 1);
   localparam logic [WORD_W-1:0] ONES      = '1;

   function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] v);
      logic [3:0]       part [8];
      logic [POP_W-1:0] total;
      total = '0;
      for (int b = 0; b < 8; b++) begin
         part[b] = '0;
         for (int i = 0; i < 8; i++) begin
            part[b] = part[b] + 4'(v[b*8+i]);
         end
      end
      for (int b = 0; b < 8; b++) begin
         total = total + POP_W'(part[b]);
      end
      return total;
   endfunction

   function automatic logic [BIT_W-1:0] low64(input logic [WORD_W-1:0] v);
      logic [2:0] byte_sel;
      logic [2:0] bit_sel;
      logic [7:0] chunk;
      byte_sel = '0;
      bit_sel  = '0;
      for (int b = 7; b >= 0; b--) begin
         if (v[b*8 +: 8] != 8'd0) begin
            byte_sel = 3'(b);
         end
      end
      chunk = v[byte_sel*8 +: 8];
      for (int i = 7; i >= 0; i--) begin
         if (chunk[i]) begin
            bit_sel = 3'(i);
         end
      end
      return {byte_sel, bit_sel};
   endfunction

   logic [MODE_W-1:0]    mode_ff;
   logic [ADDR_IN_W-1:0] base_ff, len_ff, faddr_ff;
   logic                 usable_ff;
   logic [QFRAME_W-1:0]  qframe_ff;
   logic [EXT_W-1:0]     rem_ff, sum_ff;
   logic                 in_span_ff;
   logic [FW1-1:0]       first_ff, last_ff;
   logic [FW-1:0]        lastm1_ff;
   logic [FW-1:0]        found_ff, tgt_ff;
   logic                 moved_ff;
   logic [ALLOC_W-1:0]   alloc_ff;
   logic                 in_use_ff;
   logic [ALLOC_W-1:0]   rsp_alloc_ff;
   logic                 rsp_in_use_ff;
   logic [COUNT_W-1:0]   rsp_free_ff;

   logic [AW-1:0]        word_ff, word_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [FW-1:0]        ss_ff, ss_in;
   logic [POP_W-1:0]     pop_ff, pop_in;

   logic                 mem_wr_en;
   logic [WORD_W-1:0]    mem_wr_data;
   logic [WORD_W-1:0]    rd_data;

   logic [EXT_W-1:0]     base_ext, len_ext, end_addr;
   logic [AW-1:0]        first_word, last_word_rel, start_word;
   logic [BIT_W-1:0]     lo_bit, hi_bit, start_bit, hit_bit, tgt_bit;
   logic [WORD_W-1:0]    rel_mask, alloc_mask, avail, tgt_onehot;
   logic                 hit;
   logic [ADDR_IN_W-1:0] free_frame;
   logic                 tgt_ok;
   logic [FW-1:0]        tgt_new;
   logic [FW1-1:0]       ss_next;
   logic [FW+FBL-1:0]    alloc_full;

   assign base_ext = {1'b0, base_ff};
   assign len_ext  = {1'b0, len_ff};
   assign end_addr = (len_ext > rem_ff) ? SPAN : sum_ff;

   assign first_word    = AW'(first_ff >> BIT_W);
   assign last_word_rel = AW'(lastm1_ff >> BIT_W);
   assign lo_bit        = (word_ff == first_word) ? first_ff[BIT_W-1:0] : '0;
   assign hi_bit        = (word_ff == last_word_rel) ? lastm1_ff[BIT_W-1:0] : '1;
   assign rel_mask      = (ONES << lo_bit) & (ONES >> (BIT_W'(WORD_W - 1) - hi_bit));

   assign start_word = AW'(ss_ff >> BIT_W);
   assign start_bit  = ss_ff[BIT_W-1:0];
   always_comb begin
      if (word_ff == start_word) begin
         alloc_mask = moved_ff ? ~(ONES << start_bit) : (ONES << start_bit);
      end else begin
         alloc_mask = ONES;
      end
   end
   assign avail   = ~rd_data & alloc_mask;
   assign hit     = |avail;
   assign hit_bit = low64(avail);

   assign free_frame = faddr_ff >> FBL;
   always_comb begin
      if (mode_ff == MODE_FREE) begin
         tgt_ok  = (faddr_ff != '0) && (faddr_ff[FBL-1:0] == '0)
                   && (free_frame < ADDR_IN_W'(MAX_FRAMES));
         tgt_new = FW'(free_frame);
      end else begin
         tgt_ok  = (qframe_ff < QFRAME_W'(MAX_FRAMES));
         tgt_new = FW'(qframe_ff);
      end
   end
   assign tgt_bit    = tgt_ff[BIT_W-1:0];
   assign tgt_onehot = WORD_W'(1) << tgt_bit;

   assign ss_next    = FW1'(found_ff) + FW1'(1);
   assign alloc_full = {found_ff, {FBL{1'b0}}};

   always_comb begin
      word_in     = word_ff;
      cnt_in      = cnt_ff + CW'(pop_ff);
      ss_in       = ss_ff;
      pop_in      = '0;
      mem_wr_en   = 1'b0;
      mem_wr_data = ONES;
      if (cmd.fill_start) begin
         word_in = '0;
         cnt_in  = '0;
         ss_in   = FW'(1);
      end
      if (cmd.fill_write) begin
         mem_wr_en = 1'b1;
         word_in   = word_ff + AW'(1);
      end
      if (cmd.rel_setup) begin
         word_in = first_word;
      end
      if (cmd.rel_eval) begin
         mem_wr_en   = 1'b1;
         mem_wr_data = rd_data & ~rel_mask;
         pop_in      = pop64(rd_data & rel_mask);
         word_in     = word_ff + AW'(1);
      end
      if (cmd.alloc_setup) begin
         word_in = start_word;
      end
      if (cmd.alloc_eval) begin
         if (hit) begin
            mem_wr_en   = 1'b1;
            mem_wr_data = rd_data | (WORD_W'(1) << hit_bit);
            cnt_in      = cnt_ff - CW'(1);
         end else begin
            word_in = (word_ff == LAST_WORD) ? '0 : word_ff + AW'(1);
         end
      end
      if (cmd.alloc_commit) begin
         ss_in = (ss_next >= FW1'(MAX_FRAMES)) ? FW'(1) : FW'(ss_next);
      end
      if (cmd.tgt_setup) begin
         word_in = AW'(tgt_new >> BIT_W);
      end
      if (cmd.tgt_eval && (mode_ff == MODE_FREE) && rd_data[tgt_bit]) begin
         mem_wr_en   = 1'b1;
         mem_wr_data = rd_data & ~tgt_onehot;
         cnt_in      = cnt_ff + CW'(1);
         if (tgt_ff < ss_ff) begin
            ss_in = tgt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
         cnt_ff  <= '0;
         ss_ff   <= FW'(1);
         pop_ff  <= '0;
      end else begin
         word_ff <= word_in;
         cnt_ff  <= cnt_in;
         ss_ff   <= ss_in;
         pop_ff  <= pop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff   <= req_mode;
         base_ff   <= req_region_base;
         len_ff    <= req_region_length;
         usable_ff <= req_region_usable;
         faddr_ff  <= req_free_address;
         qframe_ff <= req_query_frame;
         alloc_ff  <= '0;
         in_use_ff <= 1'b0;
      end
      if (cmd.rel_prep_a) begin
         in_span_ff <= base_ext < SPAN;
         rem_ff     <= SPAN - base_ext;
         sum_ff     <= base_ext + len_ext;
         first_ff   <= FW1'((base_ext + FB_M1) >> FBL);
      end
      if (cmd.rel_prep_b) begin
         last_ff <= FW1'(end_addr >> FBL);
         if (first_ff == '0) begin
            first_ff <= FW1'(1);
         end
      end
      if (cmd.rel_setup) begin
         lastm1_ff <= FW'(last_ff - FW1'(1));
      end
      if (cmd.alloc_setup) begin
         moved_ff <= 1'b0;
      end
      if (cmd.alloc_eval) begin
         if (hit) begin
            found_ff <= FW'({word_ff, hit_bit});
         end else begin
            moved_ff <= 1'b1;
         end
      end
      if (cmd.alloc_commit) begin
         alloc_ff <= ALLOC_W'(alloc_full);
      end
      if (cmd.tgt_setup) begin
         tgt_ff    <= tgt_new;
         in_use_ff <= (mode_ff == MODE_QUERY);
      end
      if (cmd.tgt_eval && (mode_ff == MODE_QUERY)) begin
         in_use_ff <= rd_data[tgt_bit];
      end
      if (cmd.load_rsp) begin
         rsp_alloc_ff  <= alloc_ff;
         rsp_in_use_ff <= in_use_ff;
         rsp_free_ff   <= COUNT_W'(cnt_ff);
      end
   end

   bfa_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAP_WORDS)
   ) u_map (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(word_ff),
      .wr_data(mem_wr_data),
      .rd_en  (cmd.rd_en),
      .rd_addr(word_ff),
      .rd_data(rd_data)
   );

   assign status.last_word  = (word_ff == LAST_WORD);
   assign status.rel_last   = (word_ff == last_word_rel);
   assign status.rel_go     = usable_ff && in_span_ff && (first_ff < last_ff);
   assign status.count_zero = (cnt_ff == '0);
   assign status.hit        = hit;
   assign status.tgt_ok     = tgt_ok;

   assign rsp_alloc_address = rsp_alloc_ff;
   assign rsp_frame_in_use  = rsp_in_use_ff;
   assign rsp_free_frames   = rsp_free_ff;

endmodule

[sim/tb_bitmap_frame_allocator_top.sv]
`timescale 1ns / 1ps

module tb_bitmap_frame_allocator_top;
   import bfa_pkg::*;

   localparam int FRAMES = 32768;
   localparam int FBYTES = 4096;
   localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_LAST = 3'd7;
   localparam logic [ADDR_IN_W-1:0] PAGE = ADDR_IN_W'(FBYTES);
   localparam logic [ADDR_IN_W-1:0] SPAN_BYTES = ADDR_IN_W'(FRAMES) * PAGE;
   localparam logic [ADDR_IN_W-1:0] TOP_BASE = SPAN_BYTES - PAGE;
   localparam logic [ADDR_IN_W-1:0] ONES52 = '1;
   localparam logic [QFRAME_W-1:0] ONES24 = '1;
   localparam logic [ALLOC_W-1:0] TOP_GRANT = TOP_BASE[ALLOC_W-1:0];
   localparam logic [ALLOC_W-1:0] FIRST_GRANT = PAGE[ALLOC_W-1:0];
   localparam int RANDOM_REQUESTS = 1625;
   localparam int NUM_ROWS = 25;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES = 500;
   localparam int HOLD_AFTER = 300;
   localparam int POOL_DEPTH = 512;
   localparam longint CYCLE_LIMIT = 10000000;

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [ADDR_IN_W-1:0] base;
      logic [ADDR_IN_W-1:0] length;
      logic                 usable;
      logic [ADDR_IN_W-1:0] faddr;
      logic [QFRAME_W-1:0]  qframe;
   } request_type;

   typedef struct packed {
      logic [ALLOC_W-1:0] addr;
      logic               in_use;
      logic [COUNT_W-1:0] count;
   } response_type;

   typedef struct packed {
      request_type  req;
      logic         fixed;
      response_type rsp;
   } plan_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [MODE_W-1:0]    req_mode = '0;
   logic [ADDR_IN_W-1:0] req_region_base = '0;
   logic [ADDR_IN_W-1:0] req_region_length = '0;
   logic                 req_region_usable = 1'b0;
   logic [ADDR_IN_W-1:0] req_free_address = '0;
   logic [QFRAME_W-1:0]  req_query_frame = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ALLOC_W-1:0]   rsp_alloc_address;
   logic                 rsp_frame_in_use;
   logic [COUNT_W-1:0]   rsp_free_frames;

   bit              frame_busy [FRAMES];
   int unsigned     free_count;
   int unsigned     next_fit;
   longint unsigned grant_pool [$];
   response_type    pending_responses [$];
   int unsigned     requests_taken = 0;
   int unsigned     mismatches = 0;
   int unsigned     burst_left = 0;
   longint          cycle_count = 0;
   logic            row_fixed = 1'b0;
   response_type    row_response = '0;

   // Rows with the fixed flag set carry their expected response, which follows from the request and the rows before it.
   plan_row_type plan [NUM_ROWS] = '{
      '{'{MODE_QUERY, 52'd0, 52'd0, 1'b0, 52'd0, 24'd0}, 1'b1, '{27'd0, 1'b1, 16'd0}},
      '{'{MODE_QUERY, 52'd0, 52'd0, 1'b0, 52'd0, ONES24}, 1'b1, '{27'd0, 1'b1, 16'd0}},
      '{'{MODE_ALLOC, 52'd0, 52'd0, 1'b0, 52'd0, 24'd0}, 1'b1, '{27'd0, 1'b0, 16'd0}},
      '{'{MODE_RELEASE, 52'd0, ONES52, 1'b0, 52'd0, 24'd0}, 1'b1, '{27'd0, 1'b0, 16'd0}},
      '{'{MODE_RELEASE, SPAN_BYTES, PAGE, 1'b1, 52'd0, 24'd0}, 1'b1,
        '{27'd0, 1'b0, 16'd0}},
      '{'{MODE_RELEASE, 52'd0, 52'h10000, 1'b1, 52'd0, 24'd0}, 1'b1,
        '{27'd0, 1'b0, 16'd15}},
      '{'{MODE_RELEASE, 52'h14001, 52'h3000, 1'b1, 52'd0, 24'd0}, 1'b0, '0},
      '{'{MODE_FREE, 52'd0, 52'd0, 1'b0, 52'd0, 24'd0}, 1'b0, '0},
      '{'{MODE_FREE, 52'd0, 52'd0, 1'b0, 52'h1001, 24'd0}, 1'b0, '0},
      '{'{MODE_FREE, 52'd0, 52'd0, 1'b0, SPAN_BYTES, 24'd0}, 1'b0, '0},
      '{'{MODE_FREE, 52'd0, 52'd0, 1'b0, ONES52, 24'd0}, 1'b0, '0},
      '{'{MODE_FREE, 52'd0, 52'd0, 1'b0, PAGE, 24'd0}, 1'b0, '0},
      '{'{MODE_ALLOC, 52'd0, 52'd0, 1'b0, 52'd0, 24'd0}, 1'b0, '0},
      '{'{MODE_ALLOC, 52'd0, 52'd0, 1'b0, 52'd0, 24'd0}, 1'b0, '0},
      '{'{MODE_FREE, 52'd0, 52'd0, 1'b0, PAGE, 24'd0}, 1'b0, '0},
      '{'{MODE_QUERY, 52'd0, 52'd0, 1'b0, 52'd0, 24'd1}, 1'b0, '0},
      '{'{MODE_SPARE_FIRST, ONES52, ONES52, 1'b1, ONES52, ONES24}, 1'b0, '0},
      '{'{MODE_SPARE_FIRST + 3'd1, ONES52, ONES52, 1'b1, ONES52, ONES24}, 1'b0, '0},
      '{'{MODE_SPARE_LAST, ONES52, ONES52, 1'b1, ONES52, ONES24}, 1'b0, '0},
      '{'{MODE_RESET, ONES52, ONES52, 1'b1, ONES52, ONES24}, 1'b1, '{27'd0, 1'b0, 16'd0}},
      '{'{MODE_RELEASE, TOP_BASE, ONES52, 1'b1, 52'd0, 24'd0}, 1'b1,
        '{27'd0, 1'b0, 16'd1}},
      '{'{MODE_ALLOC, 52'd0, 52'd0, 1'b0, 52'd0, 24'd0}, 1'b1,
        '{TOP_GRANT, 1'b0, 16'd0}},
      '{'{MODE_RELEASE, 52'd0, ONES52, 1'b1, 52'd0, 24'd0}, 1'b1,
        '{27'd0, 1'b0, 16'd32767}},
      '{'{MODE_ALLOC, 52'd0, 52'd0, 1'b0, 52'd0, 24'd0}, 1'b1,
        '{FIRST_GRANT, 1'b0, 16'd32766}},
      '{'{MODE_QUERY, 52'd0, 52'd0, 1'b0, 52'd0, 24'd32767}, 1'b1,
        '{27'd0, 1'b0, 16'd32766}}
   };

   bitmap_frame_allocator_top #(
      .MAX_FRAMES  (FRAMES),
      .FRAME_BYTES (FBYTES)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_region_base   (req_region_base),
      .req_region_length (req_region_length),
      .req_region_usable (req_region_usable),
      .req_free_address  (req_free_address),
      .req_query_frame   (req_query_frame),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_alloc_address (rsp_alloc_address),
      .rsp_frame_in_use  (rsp_frame_in_use),
      .rsp_free_frames   (rsp_free_frames)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void map_reset();
      foreach (frame_busy[i]) frame_busy[i] = 1'b1;
      free_count = 0;
      next_fit = 1;
   endfunction

   function automatic bit busy_at(longint unsigned f);
      if (f >= FRAMES) return 1'b1;
      return frame_busy[f];
   endfunction

   function automatic void mark_free(longint unsigned f);
      if (f != 0 && busy_at(f)) begin
         frame_busy[f] = 1'b0;
         free_count++;
      end
   endfunction

   function automatic longint unsigned grab_first(longint unsigned lo, longint unsigned hi);
      for (longint unsigned f = lo; f < hi; f++) begin
         if (!busy_at(f)) begin
            frame_busy[f] = 1'b1;
            free_count--;
            if (f + 1 >= FRAMES) next_fit = 1;
            else next_fit = 32'(f + 1);
            return f * FBYTES;
         end
      end
      return 0;
   endfunction

   function automatic void release_span(longint unsigned base, longint unsigned length);
      longint unsigned span;
      longint unsigned stop;
      span = longint'(FRAMES) * FBYTES;
      if (base >= span) return;
      stop = (length > span - base) ? span : base + length;
      for (longint unsigned f = (base + FBYTES - 1) / FBYTES; f < stop / FBYTES; f++)
         mark_free(f);
   endfunction

   function automatic void return_frame(longint unsigned addr);
      longint unsigned f;
      if (addr == 0 || addr % FBYTES != 0) return;
      f = addr / FBYTES;
      if (f >= FRAMES || !busy_at(f)) return;
      mark_free(f);
      if (f < next_fit) next_fit = 32'(f);
   endfunction

   function automatic response_type frame_map_apply(request_type r);
      response_type o;
      longint unsigned got;
      o = '0;
      case (r.mode)
         MODE_RESET: map_reset();
         MODE_RELEASE: if (r.usable) release_span(r.base, r.length);
         MODE_ALLOC: begin
            got = grab_first(next_fit, FRAMES);
            if (got == 0) got = grab_first(1, next_fit);
            if (got != 0) begin
               grant_pool.push_back(got);
               if (grant_pool.size() > POOL_DEPTH) void'(grant_pool.pop_front());
            end
            o.addr = ALLOC_W'(got);
         end
         MODE_FREE: return_frame(r.faddr);
         MODE_QUERY: o.in_use = busy_at(r.qframe);
         default: ;
      endcase
      o.count = COUNT_W'(free_count);
      return o;
   endfunction

   function automatic logic [ADDR_IN_W-1:0] wide_random();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[ADDR_IN_W-1:0];
   endfunction

   function automatic request_type random_request();
      request_type r;
      int unsigned pick;
      int unsigned flavor;
      int idx;
      r.base = wide_random();
      r.length = wide_random();
      r.usable = 1'($urandom_range(0, 1));
      r.faddr = wide_random();
      r.qframe = QFRAME_W'($urandom());
      r.mode = MODE_ALLOC;
      pick = $urandom_range(0, 99);
      flavor = $urandom_range(0, 9);
      if (pick < 1) begin
         r.mode = MODE_RESET;
      end else if (pick < 14) begin
         r.mode = MODE_RELEASE;
         if (flavor >= 3) begin
            r.usable = 1'b1;
            r.base = ADDR_IN_W'($urandom_range(0, FRAMES * FBYTES - 1));
            r.length = ADDR_IN_W'($urandom_range(0, 64 * FBYTES));
         end else if (flavor == 2) begin
            r.usable = 1'b1;
            r.base = ADDR_IN_W'($urandom_range(0, FRAMES - 1)) * PAGE;
         end
      end else if (pick < 50) begin
         r.mode = MODE_ALLOC;
      end else if (pick < 78) begin
         r.mode = MODE_FREE;
         if (flavor < 7 && grant_pool.size() != 0) begin
            idx = $urandom_range(0, grant_pool.size() - 1);
            r.faddr = ADDR_IN_W'(grant_pool[idx]);
            grant_pool.delete(idx);
         end else if (flavor == 7) begin
            r.faddr = ADDR_IN_W'($urandom_range(0, 2 * FRAMES)) * PAGE;
         end else if (flavor == 8) begin
            r.faddr = ADDR_IN_W'($urandom_range(0, FRAMES * FBYTES));
         end
      end else if (pick < 96) begin
         r.mode = MODE_QUERY;
         if (flavor < 8) r.qframe = QFRAME_W'($urandom_range(0, FRAMES - 1));
      end else begin
         r.mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      end
      return r;
   endfunction

   function automatic void report_response(string what, response_type want,
                                           response_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: expected addr=%h in_use=%b free=%0d, got addr=%h in_use=%b free=%0d",
                  what, want.addr, want.in_use, want.count, got.addr, got.in_use, got.count);
   endfunction

   task automatic offer(input request_type r, input logic fixed, input response_type rsp);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_mode <= r.mode;
      req_region_base <= r.base;
      req_region_length <= r.length;
      req_region_usable <= r.usable;
      req_free_address <= r.faddr;
      req_query_frame <= r.qframe;
      row_fixed <= fixed;
      row_response <= rsp;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      map_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i]) offer(plan[i].req, plan[i].fixed, plan[i].rsp);
      repeat (RANDOM_REQUESTS) offer(random_request(), 1'b0, '0);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("bitmap_frame_allocator_top regression: pass");
      end else begin
         $display("bitmap_frame_allocator_top regression: fail");
      end
      $finish;
   end

   // The receiver stalls on its own pattern and once holds off long enough to back up requests.
   initial begin
      int unsigned seg_len;
      int unsigned style;
      bit held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         seg_len = $urandom_range(10, 200);
         style = $urandom_range(0, 2);
         if (!held && requests_taken >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         repeat (seg_len) begin
            case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      response_type want;
      response_type got;
      request_type seen;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_alloc_address, rsp_frame_in_use, rsp_free_frames};
            if (pending_responses.size() == 0) begin
               report_response("response with no request pending", '0, got);
            end else begin
               want = pending_responses.pop_front();
               if (want.addr !== got.addr || want.in_use !== got.in_use ||
                   want.count !== got.count)
                  report_response("response mismatch", want, got);
            end
         end
         if (req_valid && req_ready) begin
            seen = '{req_mode, req_region_base, req_region_length, req_region_usable,
                     req_free_address, req_query_frame};
            want = frame_map_apply(seen);
            pending_responses.push_back(row_fixed ? row_response : want);
            requests_taken++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bitmap_frame_allocator_top regression: fail");
         $finish;
      end
   end

endmodule
